### sv/slot_allocator_free_stack_top_macros.svh
// Assertion macros used by the slot allocator control (safs_ctrl).
// Depends on nothing; expects a clock named clk and a reset named rst in scope.
`ifndef SLOT_ALLOCATOR_FREE_STACK_TOP_MACROS_SVH
`define SLOT_ALLOCATOR_FREE_STACK_TOP_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define SAFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SAFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/safs_pkg.sv
// Shared types and codes for the slot allocator with free stack.
// Used by safs_stack_mem, safs_ctrl and the top level.
package safs_pkg;

  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam status_t ST_ALLOC    = 2'd0;
  localparam status_t ST_RELEASED = 2'd1;
  localparam status_t ST_IGNORED  = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  // One stack access per transaction: a push, a pop, or nothing.
  typedef struct packed {
    logic  push;
    logic  pop;
    slot_t wdata;
  } mem_cmd_t;

endpackage

### sv/safs_stack_mem.sv
// Free stack storage: single-port synchronous RAM with a registered read.
// Depends on safs_pkg for the command struct and slot type.
module safs_stack_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  safs_pkg::mem_cmd_t       cmd,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output safs_pkg::slot_t          rdata
);
  import safs_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[addr] <= cmd.wdata;
    end
    if (cmd.pop) begin
      rdata <= mem[addr];
    end
  end

endmodule

### sv/safs_ctrl.sv
// Allocator control: length, low mark and stack depth registers, request
// decode, stack command generation and the result register. Uses safs_pkg.
`include "slot_allocator_free_stack_top_macros.svh"

module safs_ctrl #(
  parameter int CAPACITY = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        op,
  input  safs_pkg::slot_t             slot,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output safs_pkg::slot_t             slot_out,
  output safs_pkg::status_t           status,
  output safs_pkg::mem_cmd_t          mem_cmd,
  output logic [$clog2(CAPACITY)-1:0] mem_addr,
  input  safs_pkg::slot_t             mem_rdata
);
  import safs_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [CW-1:0] used_length, used_length_next;
  logic [CW-1:0] low_mark, low_mark_next;
  logic [CW-1:0] free_count, free_count_next;

  logic    rsp_from_mem;
  slot_t   rsp_slot;
  status_t rsp_status;

  slot_t   res_slot;
  status_t res_status;
  logic    res_from_mem;
  logic    accept;

  logic [CW-1:0] low_dec, used_dec, count_dec;
  logic [XW-1:0] slot_x, used_x, low_x;
  logic [XW-1:0] low_dec_x, used_cur_x;

  assign accept    = req_valid && req_ready;
  assign req_ready = !rsp_valid || rsp_ready;

  assign low_dec    = low_mark - ONE_C;
  assign used_dec   = used_length - ONE_C;
  assign count_dec  = free_count - ONE_C;
  assign slot_x     = XW'(slot);
  assign used_x     = XW'(used_length);
  assign low_x      = XW'(low_mark);
  assign low_dec_x  = XW'(low_dec);
  assign used_cur_x = XW'(used_length);

  always_comb begin
    used_length_next = used_length;
    low_mark_next    = low_mark;
    free_count_next  = free_count;
    res_slot         = '0;
    res_status       = ST_ALLOC;
    res_from_mem     = 1'b0;
    mem_cmd.push     = 1'b0;
    mem_cmd.pop      = 1'b0;
    mem_cmd.wdata    = slot;
    mem_addr         = free_count[AW-1:0];

    if (op == OP_ALLOC) begin
      priority if (low_mark != '0) begin
        low_mark_next = low_dec;
        res_slot      = low_dec_x[SLOT_W-1:0];
      end else if (free_count != '0) begin
        // pop: the slot comes back registered from the stack in the next cycle
        free_count_next = count_dec;
        mem_cmd.pop     = 1'b1;
        mem_addr        = count_dec[AW-1:0];
        res_from_mem    = 1'b1;
      end else if (used_length < CAP_C) begin
        used_length_next = used_length + ONE_C;
        res_slot         = used_cur_x[SLOT_W-1:0];
      end else begin
        res_status = ST_FULL;
      end
    end else begin
      res_slot = slot;
      if (slot_x >= used_x) begin
        res_status = ST_IGNORED;
      end else begin
        res_status = ST_RELEASED;
        priority if (slot_x == XW'(used_dec)) begin
          used_length_next = used_dec;
        end else if (slot_x == low_x) begin
          low_mark_next = low_mark + ONE_C;
        end else if (free_count < CAP_C) begin
          mem_cmd.push    = 1'b1;
          free_count_next = free_count + ONE_C;
        end
        // mark met the end: the whole array is free again
        if (low_mark_next == used_length_next) begin
          used_length_next = '0;
          low_mark_next    = '0;
          free_count_next  = '0;
        end
      end
    end

    if (!accept) begin
      mem_cmd.push = 1'b0;
      mem_cmd.pop  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_length  <= '0;
      low_mark     <= '0;
      free_count   <= '0;
      rsp_valid    <= 1'b0;
      rsp_from_mem <= 1'b0;
    end else begin
      if (accept) begin
        used_length  <= used_length_next;
        low_mark     <= low_mark_next;
        free_count   <= free_count_next;
        rsp_valid    <= 1'b1;
        rsp_from_mem <= res_from_mem;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_slot   <= res_slot;
      rsp_status <= res_status;
    end
  end

  assign slot_out = rsp_from_mem ? mem_rdata : rsp_slot;
  assign status   = rsp_status;

  `SAFS_ASSERT(a_mark_below_len, (low_mark <= used_length), "low mark above used length")
  `SAFS_ASSERT(a_count_bound, (free_count <= CAP_C), "free stack depth above capacity")
  `SAFS_ASSERT(a_mark_meets_len, ((low_mark == used_length) |-> (used_length == '0 && free_count == '0)), "mark met length without clearing")
  `SAFS_ASSERT(a_pop_result, ((accept && mem_cmd.pop) |=> (rsp_valid && rsp_from_mem && status == ST_ALLOC)), "pop did not yield an allocation result")
  `SAFS_ASSERT_ALWAYS(a_no_dual_access, !(mem_cmd.push && mem_cmd.pop), "push and pop in one cycle")

endmodule

### sv/slot_allocator_free_stack_top.sv
// A result is valid in the cycle after its request is accepted. Throughput: one
// request per cycle while results drain; the single result register accepts a new
// request in the same cycle its held result is taken, and the free stack RAM port
// handles one push or one pop per request. Reset (rst, synchronous) empties the
// allocator at once: length, low mark and stack depth go to zero, no clearing pass.
//
// Top level of the slot allocator. Depends on safs_pkg, safs_ctrl, safs_stack_mem.
module slot_allocator_free_stack_top #(
  parameter int CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              op,
  input  safs_pkg::slot_t   slot,
  // result channel
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output safs_pkg::slot_t   slot_out,
  output safs_pkg::status_t status
);
  import safs_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  // Stack command and address from control; popped slot returns registered,
  // so a popping request's result is muxed from the RAM output in the result cycle.
  mem_cmd_t        mem_cmd;
  logic [AW-1:0]   mem_addr;
  slot_t           mem_rdata;

  safs_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .op        (op),
    .slot      (slot),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .slot_out  (slot_out),
    .status    (status),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_rdata (mem_rdata)
  );

  // Free stack: a push writes at the accept edge and a pop reads at the accept
  // edge, so back-to-back push/pop on one entry never overlap in time.
  safs_stack_mem #(
    .DEPTH (CAPACITY)
  ) u_stack (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .rdata (mem_rdata)
  );

endmodule
